@@ rtl/srr_pkg.sv @@
package srr_pkg;

  localparam int SEQ_W      = 8;
  localparam int SRC_FW     = 4;
  localparam int PAY_W      = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = $clog2(SEQ_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0]  REG_WINDOW   = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_OWN_ID   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 4'd8;
  localparam logic [ID_W-1:0]       OWN_ID_RESET = 4'd0;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef struct packed {
    logic              crc_ok;
    logic              is_ack;
    logic [SRC_FW-1:0] source;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  payload_ref;
    logic              msg_end;
  } frame_t;

  typedef struct packed {
    logic              kind;
    logic [SRC_FW-1:0] peer;
    logic [ID_W-1:0]   sender_id;
    logic [SEQ_W-1:0]  seq_out;
    logic [PAY_W-1:0]  payload_out;
    logic              message_done;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
    logic             msg_end;
  } slot_t;

endpackage

@@ rtl/srr_frame_if.sv @@
interface srr_frame_if;
  logic            valid;
  logic            ready;
  srr_pkg::frame_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ rtl/srr_result_if.sv @@
interface srr_result_if;
  logic             valid;
  logic             ready;
  srr_pkg::result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ rtl/srr_cfg_if.sv @@
interface srr_cfg_if;
  logic             valid;
  logic             ready;
  srr_pkg::cfg_wr_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ rtl/selective_repeat_receiver.sv @@
// A stored in-order frame passes ST_LOAD, ST_MOD, ST_DRAIN and ST_FETCH into the
// output register. Frames are taken only in ST_IDLE, so a new item waits for the last;
// the path holds the 8-step remainder unit, each delivery is one slot memory read.
// Dropped items give no result; output stalls hold the FSM in ST_FETCH and ST_ACK.
// Reset: synchronous; all receive bases zero, all slots empty, window 8, own_id 0.
module selective_repeat_receiver #(
  parameter int NUM_SOURCES = 16,
  parameter int WINDOW_MAX = 8
) (
  input logic          clk,
  input logic          rst,
  srr_cfg_if.sink      cfg,
  srr_frame_if.sink    frame_in,
  srr_result_if.source result_out
);
  import srr_pkg::*;

  localparam int SRC_W  = $clog2(NUM_SOURCES);
  localparam int EW     = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int DEPTH  = NUM_SOURCES * WINDOW_MAX;
  localparam int CA_W   = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FETCH = 3'd4;
  localparam logic [2:0] ST_ACK   = 3'd5;

  logic [2:0]            state;
  logic [CFG_DATA_W-1:0] win_len;
  logic [ID_W-1:0]       own_id;
  logic [EW-1:0]         ws_eff;

  logic [SRC_FW-1:0]     f_source;
  logic [SEQ_W-1:0]      f_seq;
  logic [PAY_W-1:0]      f_payload;
  logic                  f_msg_end;
  logic [SRC_W-1:0]      f_src_idx;
  logic [CA_W-1:0]       row_addr;

  logic [SEQ_W-1:0]      base_r;
  logic [WINDOW_MAX-1:0] full_r;
  logic [SLOT_W-1:0]     base_slot;
  logic [SLOT_W-1:0]     base_slot_inc;

  logic                  out_valid;
  result_t               out_item;
  logic                  out_free;

  logic                  in_acc;
  logic                  wanted;
  logic                  row_rd_en;
  logic [SEQ_W-1:0]      row_base;
  logic [WINDOW_MAX-1:0] row_full;
  logic                  row_wr_en;

  logic                  mod_start;
  logic                  mod_done;
  logic [SLOT_W-1:0]     rem_seq;
  logic [SLOT_W-1:0]     rem_base;

  logic [SEQ_W-1:0]      diff;
  logic                  dup;
  logic                  in_win;
  logic                  store;
  logic                  drain_hit;
  logic                  deliver;
  logic                  ack_go;
  slot_t                 slot_wr;
  slot_t                 slot_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= WINDOW_RESET;
      own_id  <= OWN_ID_RESET;
    end else if (cfg.valid) begin
      case (cfg.item.index)
        REG_WINDOW: win_len <= cfg.item.value;
        REG_OWN_ID: own_id <= cfg.item.value;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_len == '0) begin
      ws_eff = EW'(1);
    end else if (int'(win_len) > WINDOW_MAX) begin
      ws_eff = EW'(WINDOW_MAX);
    end else begin
      ws_eff = EW'(win_len);
    end
  end

  assign frame_in.ready = (state == ST_IDLE);
  assign in_acc    = frame_in.valid && frame_in.ready;
  assign wanted    = frame_in.item.crc_ok && !frame_in.item.is_ack &&
                     (int'(frame_in.item.source) < NUM_SOURCES);
  assign row_rd_en = in_acc && wanted;

  assign f_src_idx = SRC_W'(f_source);
  assign row_addr  = CA_W'(f_src_idx) * CA_W'(WINDOW_MAX);

  assign out_free  = !out_valid || result_out.ready;
  assign mod_start = (state == ST_LOAD);

  assign diff      = f_seq - base_r;
  assign dup       = diff[SEQ_W-1];
  assign in_win    = int'(diff) < int'(ws_eff);
  assign store     = (state == ST_MOD) && mod_done && !dup && in_win && !full_r[rem_seq];
  assign drain_hit = (state == ST_DRAIN) && full_r[base_slot];
  assign deliver   = (state == ST_FETCH) && out_free;
  assign ack_go    = (state == ST_ACK) && out_free;
  assign row_wr_en = ack_go;

  // base wrapping to zero restarts at slot zero
  assign base_slot_inc = (base_r == '1) ? '0 :
                         (int'(base_slot) + 1 == int'(ws_eff)) ? '0
                                                               : base_slot + SLOT_W'(1);

  assign slot_wr.seq     = f_seq;
  assign slot_wr.payload = f_payload;
  assign slot_wr.msg_end = f_msg_end;

  srr_row_mem #(
    .NUM_SOURCES(NUM_SOURCES),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_row_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (row_rd_en),
    .rd_addr(SRC_W'(frame_in.item.source)),
    .rd_base(row_base),
    .rd_full(row_full),
    .wr_en  (row_wr_en),
    .wr_addr(f_src_idx),
    .wr_base(base_r),
    .wr_full(full_r)
  );

  srr_rem_unit #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_rem_unit (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .num_a  (f_seq),
    .num_b  (row_base),
    .divisor(ws_eff),
    .done   (mod_done),
    .rem_a  (rem_seq),
    .rem_b  (rem_base)
  );

  srr_slot_mem #(
    .DEPTH(DEPTH)
  ) u_slot_mem (
    .clk    (clk),
    .wr_en  (store),
    .wr_addr(row_addr + CA_W'(rem_seq)),
    .wr_data(slot_wr),
    .rd_en  (drain_hit),
    .rd_addr(row_addr + CA_W'(base_slot)),
    .rd_data(slot_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (deliver || ack_go) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (row_rd_en) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_MOD;
        ST_MOD: begin
          if (mod_done) begin
            if (dup) begin
              state <= ST_ACK;
            end else if (!in_win) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: state <= drain_hit ? ST_FETCH : ST_ACK;
        ST_FETCH: begin
          if (out_free) begin
            state <= ST_DRAIN;
          end
        end
        ST_ACK: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_source  <= frame_in.item.source;
      f_seq     <= frame_in.item.seq;
      f_payload <= frame_in.item.payload_ref;
      f_msg_end <= frame_in.item.msg_end;
    end
    if (state == ST_LOAD) begin
      base_r <= row_base;
      full_r <= row_full;
    end
    if ((state == ST_MOD) && mod_done) begin
      base_slot <= rem_base;
    end
    if (store) begin
      full_r[rem_seq] <= 1'b1;
    end
    if (deliver) begin
      full_r[base_slot] <= 1'b0;
      base_r            <= base_r + SEQ_W'(1);
      base_slot         <= base_slot_inc;
      out_item.kind         <= KIND_FRAME;
      out_item.peer         <= f_source;
      out_item.sender_id    <= '0;
      out_item.seq_out      <= slot_q.seq;
      out_item.payload_out  <= slot_q.payload;
      out_item.message_done <= slot_q.msg_end;
      out_item.last         <= 1'b0;
    end
    if (ack_go) begin
      out_item.kind         <= KIND_ACK;
      out_item.peer         <= f_source;
      out_item.sender_id    <= own_id;
      out_item.seq_out      <= base_r;
      out_item.payload_out  <= '0;
      out_item.message_done <= 1'b0;
      out_item.last         <= 1'b1;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.item  = out_item;

  a_frame_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_FRAME) |-> !out_item.last)
    else $error("delivered item marked last");

  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_ACK) |->
      out_item.last && (out_item.payload_out == '0) && !out_item.message_done)
    else $error("ack item malformed");

  a_bad_crc_drop: assert property (@(posedge clk) disable iff (rst)
    in_acc && !frame_in.item.crc_ok |=> state == ST_IDLE)
    else $error("bad checksum item not dropped");

  a_fetch_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> full_r[base_slot])
    else $error("fetch from empty slot");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> int'(base_slot) < int'(ws_eff))
    else $error("base slot outside window");

endmodule

@@ rtl/srr_rem_unit.sv @@
module srr_rem_unit #(
  parameter int WINDOW_MAX = 8,
  localparam int EW = $clog2(WINDOW_MAX + 1),
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [srr_pkg::SEQ_W-1:0] num_a,
  input  logic [srr_pkg::SEQ_W-1:0] num_b,
  input  logic [EW-1:0]             divisor,
  output logic                      done,
  output logic [SLOT_W-1:0]         rem_a,
  output logic [SLOT_W-1:0]         rem_b
);
  import srr_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SEQ_W-1:0] sa;
  logic [SEQ_W-1:0] sb;
  logic [EW:0]      ra;
  logic [EW:0]      rb;
  logic [EW-1:0]    dv;

  function automatic logic [EW:0] step(input logic [EW:0] r, input logic b,
                                       input logic [EW-1:0] d);
    logic [EW:0] t;
    t = {r[EW-1:0], b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(SEQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sa <= num_a;
      sb <= num_b;
      ra <= '0;
      rb <= '0;
      dv <= divisor;
    end else if (busy) begin
      ra <= step(ra, sa[SEQ_W-1], dv);
      rb <= step(rb, sb[SEQ_W-1], dv);
      sa <= {sa[SEQ_W-2:0], 1'b0};
      sb <= {sb[SEQ_W-2:0], 1'b0};
    end
  end

  assign rem_a = SLOT_W'(ra);
  assign rem_b = SLOT_W'(rb);

endmodule

@@ rtl/srr_row_mem.sv @@
module srr_row_mem #(
  parameter int NUM_SOURCES = 16,
  parameter int WINDOW_MAX = 8,
  localparam int SRC_W = $clog2(NUM_SOURCES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [SRC_W-1:0]          rd_addr,
  output logic [srr_pkg::SEQ_W-1:0] rd_base,
  output logic [WINDOW_MAX-1:0]     rd_full,
  input  logic                      wr_en,
  input  logic [SRC_W-1:0]          wr_addr,
  input  logic [srr_pkg::SEQ_W-1:0] wr_base,
  input  logic [WINDOW_MAX-1:0]     wr_full
);
  import srr_pkg::*;

  localparam int RW = SEQ_W + WINDOW_MAX;

  logic [RW-1:0]          mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] vld;
  logic [RW-1:0]          rd_q;
  logic                   rd_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_base, wr_full};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rd_v <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v <= vld[rd_addr];
      end
    end
  end

  assign rd_base = rd_v ? rd_q[RW-1:WINDOW_MAX] : '0;
  assign rd_full = rd_v ? rd_q[WINDOW_MAX-1:0] : '0;

endmodule

@@ rtl/srr_slot_mem.sv @@
module srr_slot_mem #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  srr_pkg::slot_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output srr_pkg::slot_t rd_data
);
  import srr_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
